### rtl/whef_pkg.sv
package whef_pkg;

   localparam int BIN_COUNT_DEF = 1024;

   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_RANGE_LOW     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RANGE_HIGH    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIN_FACTOR    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOG_SCALE     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOG_RANGE_LOW = 3'd4;

   localparam logic [1:0] PLACE_IN_RANGE  = 2'd0;
   localparam logic [1:0] PLACE_UNDERFLOW = 2'd1;
   localparam logic [1:0] PLACE_OVERFLOW  = 2'd2;

   localparam int REQ_DATA_W = 96;
   localparam int RSP_DATA_W = 240;

   // round(65536*log2(1+i/16)) for i = 0..16.
   function automatic logic [16:0] log_frac(input logic [4:0] idx);
      logic [16:0] r;
      case (idx)
         5'd0:  r = 17'd0;
         5'd1:  r = 17'd5732;
         5'd2:  r = 17'd11136;
         5'd3:  r = 17'd16248;
         5'd4:  r = 17'd21098;
         5'd5:  r = 17'd25711;
         5'd6:  r = 17'd30109;
         5'd7:  r = 17'd34312;
         5'd8:  r = 17'd38336;
         5'd9:  r = 17'd42196;
         5'd10: r = 17'd45904;
         5'd11: r = 17'd49472;
         5'd12: r = 17'd52911;
         5'd13: r = 17'd56229;
         5'd14: r = 17'd59434;
         5'd15: r = 17'd62534;
         5'd16: r = 17'd65536;
         default: r = 17'd0;
      endcase
      return r;
   endfunction

   // Saturating add of a sign-extended 32-bit weight to a 48-bit sum.
   function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [31:0] b);
      logic [48:0] s;
      s = {a[47], a} + {{17{b[31]}}, b};
      if (s[48] != s[47]) begin
         return s[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
      end
      return s[47:0];
   endfunction

endpackage

### rtl/whef_ram.sv
module whef_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

### rtl/weighted_histogram_error_fill_unit.sv
// Weighted histogram with errors added in quadrature, Q16.16 fixed point. Each
// item carries a value, a weight and an error; the weight always goes to the
// running total, and either to the underflow or overflow sum or to one bin,
// chosen linearly or on a log2 scale, where the squared error is also summed
// and its root is returned. One result item is produced per input item, and
// the block works on one item at a time. A linear in-range item passes through
// scaling, the bin read, the bin update and a 32-step square root of the
// updated squared-error sum before its result; an out-of-range item goes
// straight to the result. In log mode the leading-one search of the value and
// the table interpolation come before the scaling. After reset the block sweeps
// both bin memories to clear them and accepts no item meanwhile; configuration
// writes are taken at all times but must only be made while the block is idle.
module weighted_histogram_error_fill_unit
   import whef_pkg::*;
#(
   parameter int BIN_COUNT = BIN_COUNT_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // sample_value[31:0], sample_weight[63:32], sample_error[95:64]
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // placement[1:0], bin_index[11:2], bin_total[59:12], bin_error[91:60],
   // weight_total[139:92], underflow_total[187:140], overflow_total[235:188],
   // zero padding[239:236]
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]            csr_data
);

   localparam int IW = $clog2(BIN_COUNT);
   localparam int EW = (IW > 10) ? IW : 10;
   localparam logic [IW-1:0] LAST_BIN = IW'(BIN_COUNT - 1);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_NORM, S_LOGMUL, S_LOGSUM, S_SCALE, S_READ,
      S_MODIFY, S_SQRT, S_OUT
   } state_type;

   state_type state_ff;

   // Configuration registers.
   logic [31:0] range_low_ff, range_high_ff, bin_factor_ff, log_range_low_ff;
   logic        log_scale_ff;

   // Per-item working registers.
   logic [31:0] weight_ff;
   logic [63:0] sq_ff;
   logic [30:0] mant_ff;
   logic [4:0]  lead_ff;
   logic [38:0] interp_prod_ff;
   logic [16:0] frac_lo_ff;
   logic signed [33:0] diff_ff;
   logic [IW-1:0] idx_ff, clr_addr_ff;
   logic [47:0] bin_total_ff;
   logic [63:0] root_rem_ff, root_res_ff, root_bit_ff;
   logic [4:0]  root_step_ff;
   logic [1:0]  place_ff;

   logic [47:0] weight_sum_ff, under_sum_ff, over_sum_ff;

   logic                   rsp_valid_ff;
   logic [RSP_DATA_W-1:0]  rsp_data_ff;

   // Memory ports.
   logic          ram_we;
   logic [IW-1:0] ram_waddr;
   logic [47:0]   wgt_wdata, wgt_rdata;
   logic [63:0]   err_wdata, err_rdata;

   logic        req_fire;
   logic signed [33:0] s_val, s_lo, s_hi;
   logic        is_under, is_over;
   logic [4:0]  frac_idx;
   logic [16:0] frac_hi;
   logic [16:0] interp;
   logic signed [33:0] log2_val;
   logic [63:0] scale_prod;
   logic [47:0] new_wgt;
   logic [64:0] sq_sum;
   logic [63:0] new_sq;
   logic [63:0] root_try;
   logic [EW-1:0] idx_ext;

   assign req_fire   = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      s_val    = 34'($signed(req_tdata[31:0]));
      s_lo     = 34'($signed(range_low_ff));
      s_hi     = 34'($signed(range_high_ff));
      is_under = (s_val < s_lo) || (log_scale_ff && (s_val <= 34'sd0));
      is_over  = (s_val > s_hi);

      // Mantissa bits below the leading one select the table entry.
      frac_idx   = {1'b0, mant_ff[29:26]};
      frac_hi    = log_frac(frac_idx + 5'd1);
      interp     = frac_lo_ff + 17'(interp_prod_ff >> 26);
      log2_val   = $signed({13'd0, lead_ff, 16'd0}) - 34'sd1048576 + $signed({17'd0, interp});

      scale_prod = 64'(diff_ff[31:0]) * 64'(bin_factor_ff);

      new_wgt = sat_add48(wgt_rdata, weight_ff);
      sq_sum  = {1'b0, err_rdata} + {1'b0, sq_ff};
      new_sq  = sq_sum[64] ? {64{1'b1}} : sq_sum[63:0];

      root_try = root_res_ff + root_bit_ff;
      idx_ext  = EW'(idx_ff);

      ram_we    = (state_ff == S_CLEAR) || (state_ff == S_MODIFY);
      ram_waddr = (state_ff == S_CLEAR) ? clr_addr_ff : idx_ff;
      wgt_wdata = (state_ff == S_CLEAR) ? 48'd0 : new_wgt;
      err_wdata = (state_ff == S_CLEAR) ? 64'd0 : new_sq;
   end

   whef_ram #(.WIDTH(48), .DEPTH(BIN_COUNT)) u_weight_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (wgt_wdata),
      .rd_addr (idx_ff),
      .rd_data (wgt_rdata)
   );

   whef_ram #(.WIDTH(64), .DEPTH(BIN_COUNT)) u_error_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (err_wdata),
      .rd_addr (idx_ff),
      .rd_data (err_rdata)
   );

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         range_low_ff     <= 32'd0;
         range_high_ff    <= 32'h7FFF_FFFF;
         bin_factor_ff    <= 32'd65536;
         log_scale_ff     <= 1'b0;
         log_range_low_ff <= 32'd0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_RANGE_LOW:     range_low_ff     <= csr_data;
            CSR_RANGE_HIGH:    range_high_ff    <= csr_data;
            CSR_BIN_FACTOR:    bin_factor_ff    <= csr_data;
            CSR_LOG_SCALE:     log_scale_ff     <= csr_data[0];
            CSR_LOG_RANGE_LOW: log_range_low_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Sequencer with its working registers and the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_addr_ff   <= '0;
         weight_sum_ff <= 48'd0;
         under_sum_ff  <= 48'd0;
         over_sum_ff   <= 48'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         // In the output state the result register is reloaded below instead.
         if (rsp_valid_ff && rsp_tready && (state_ff != S_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_CLEAR: begin
               clr_addr_ff <= clr_addr_ff + 1'b1;
               if (clr_addr_ff == LAST_BIN) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_fire) begin
                  weight_ff     <= req_tdata[63:32];
                  sq_ff         <= 64'(req_tdata[95:64]) * 64'(req_tdata[95:64]);
                  weight_sum_ff <= sat_add48(weight_sum_ff, req_tdata[63:32]);
                  idx_ff        <= '0;
                  bin_total_ff  <= 48'd0;
                  root_res_ff   <= 64'd0;
                  mant_ff       <= req_tdata[30:0];
                  lead_ff       <= 5'd30;
                  diff_ff       <= s_val - s_lo;
                  if (is_under) begin
                     under_sum_ff <= sat_add48(under_sum_ff, req_tdata[63:32]);
                     place_ff     <= PLACE_UNDERFLOW;
                     state_ff     <= S_OUT;
                  end else if (is_over) begin
                     over_sum_ff <= sat_add48(over_sum_ff, req_tdata[63:32]);
                     place_ff    <= PLACE_OVERFLOW;
                     state_ff    <= S_OUT;
                  end else begin
                     place_ff <= PLACE_IN_RANGE;
                     state_ff <= log_scale_ff ? S_NORM : S_SCALE;
                  end
               end
            end
            S_NORM: begin
               // Shift one place a cycle until the leading one reaches bit 30.
               if ((lead_ff != 5'd0) && !mant_ff[30]) begin
                  mant_ff <= mant_ff << 1;
                  lead_ff <= lead_ff - 5'd1;
               end else begin
                  state_ff <= S_LOGMUL;
               end
            end
            S_LOGMUL: begin
               frac_lo_ff     <= log_frac(frac_idx);
               interp_prod_ff <= 39'(frac_hi - log_frac(frac_idx)) * 39'(mant_ff[25:0]);
               state_ff       <= S_LOGSUM;
            end
            S_LOGSUM: begin
               diff_ff  <= log2_val - 34'($signed(log_range_low_ff));
               state_ff <= S_SCALE;
            end
            S_SCALE: begin
               if (diff_ff[33] || (diff_ff == 34'sd0)) begin
                  idx_ff <= '0;
               end else if (scale_prod[63:32] > 32'(BIN_COUNT - 1)) begin
                  idx_ff <= LAST_BIN;
               end else begin
                  idx_ff <= IW'(scale_prod[63:32]);
               end
               state_ff <= S_READ;
            end
            S_READ: begin
               // Read address is idx_ff; data is registered in the memories.
               state_ff <= S_MODIFY;
            end
            S_MODIFY: begin
               bin_total_ff <= new_wgt;
               root_rem_ff  <= new_sq;
               root_res_ff  <= 64'd0;
               root_bit_ff  <= 64'h4000_0000_0000_0000;
               root_step_ff <= 5'd0;
               state_ff     <= S_SQRT;
            end
            S_SQRT: begin
               if (root_rem_ff >= root_try) begin
                  root_rem_ff <= root_rem_ff - root_try;
                  root_res_ff <= (root_res_ff >> 1) + root_bit_ff;
               end else begin
                  root_res_ff <= root_res_ff >> 1;
               end
               root_bit_ff  <= root_bit_ff >> 2;
               root_step_ff <= root_step_ff + 5'd1;
               if (root_step_ff == 5'd31) begin
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {4'd0, over_sum_ff, under_sum_ff, weight_sum_ff,
                                   root_res_ff[31:0], bin_total_ff, idx_ext[9:0], place_ff};
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // The bin memories are written only by the clearing sweep or a bin update.
   a_write_source: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> ((state_ff == S_CLEAR) || (state_ff == S_MODIFY)))
      else $error("bin memory written outside clear or update");

   // An accepted item always leaves the idle state.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff != S_IDLE))
      else $error("item accepted but sequencer stayed idle");

   // A result is loaded only when the result register is free or being emptied.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> $stable(rsp_data_ff))
      else $error("pending result overwritten");

   // The square root leaves after exactly 32 steps.
   a_sqrt_exit: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_SQRT) && (root_step_ff == 5'd31)) |=> (state_ff == S_OUT))
      else $error("square root step count wrong");

endmodule

### tb/sv/weighted_histogram_error_fill_unit_tb.sv
module weighted_histogram_error_fill_unit_tb;
   import whef_pkg::*;

   localparam longint SUM_MAX = 64'sd140737488355327;
   localparam longint SUM_MIN = -64'sd140737488355328;
   localparam int LAST_BIN = BIN_COUNT_DEF - 1;
   // Longest path through the block is a log-mode in-range item.
   localparam int SETTLE_CYCLES = 100;
   localparam int CYCLE_LIMIT = 2000000;

   typedef struct packed {
      logic [1:0]  placement;
      logic [9:0]  bin_index;
      logic [47:0] bin_total;
      logic [31:0] bin_error;
      logic [47:0] weight_total;
      logic [47:0] underflow_total;
      logic [47:0] overflow_total;
   } fill_result_type;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   // sample_value[31:0], sample_weight[63:32], sample_error[95:64]
   logic [REQ_DATA_W-1:0] req_tdata;
   logic rsp_tvalid;
   logic rsp_tready;
   // placement[1:0], bin_index[11:2], bin_total[59:12], bin_error[91:60],
   // weight_total[139:92], underflow_total[187:140], overflow_total[235:188]
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic csr_valid;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [31:0] csr_data;

   weighted_histogram_error_fill_unit uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // Shadow copy of the configuration registers, updated on each accepted write.
   int          edge_low;
   int          edge_high;
   bit [31:0]   bins_per_unit;
   bit          log_binning;
   int          log_edge_low;

   // Shadow copy of the histogram contents.
   longint      bin_weight [BIN_COUNT_DEF];
   bit [63:0]   bin_error_sq [BIN_COUNT_DEF];
   longint      weight_sum;
   longint      underflow_sum;
   longint      overflow_sum;

   fill_result_type pending_fills[$];
   int unsigned  error_count;
   int unsigned  cycle_count;
   bit           no_idling;

   // Fraction table of the log2 approximation, round(65536*log2(1+i/16)).
   int unsigned log_fraction [17] = '{0, 5732, 11136, 16248, 21098, 25711, 30109,
      34312, 38336, 42196, 45904, 49472, 52911, 56229, 59434, 62534, 65536};

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic longint add_saturated(longint sum, int weight);
      longint s;
      s = sum + longint'(weight);
      if (s > SUM_MAX) return SUM_MAX;
      if (s < SUM_MIN) return SUM_MIN;
      return s;
   endfunction

   // Leading-one position gives the integer part; the four bits below it pick
   // a table entry and the remaining 26 bits interpolate between entries.
   function automatic longint log2_fixed(bit [31:0] v);
      int p;
      bit [31:0] m;
      bit [3:0] sel;
      bit [25:0] rem;
      longint lo, hi;
      p = 30;
      while (p > 0 && v[p] == 1'b0) p--;
      m = v << (30 - p);
      sel = m[29:26];
      rem = m[25:0];
      lo = log_fraction[sel];
      hi = log_fraction[sel + 1];
      return longint'(p - 16) * 65536 + lo + (((hi - lo) * longint'(rem)) >>> 26);
   endfunction

   function automatic bit [31:0] root_floor(bit [63:0] x);
      bit [63:0] res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= res + b) begin
            x -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res[31:0];
   endfunction

   function automatic int unsigned bin_from_offset(longint offset);
      bit [63:0] q;
      if (offset <= 0) return 0;
      q = (64'(offset) * {32'd0, bins_per_unit}) >> 32;
      if (q > LAST_BIN) return LAST_BIN;
      return q[31:0];
   endfunction

   // Applies one sample to the shadow histogram and returns what the block
   // should report for it.
   function automatic fill_result_type fill_sample(int value, int weight, bit [31:0] err);
      fill_result_type r;
      int unsigned b;
      bit [63:0] sq;
      r = '0;
      weight_sum = add_saturated(weight_sum, weight);
      if (value < edge_low || (log_binning && value <= 0)) begin
         underflow_sum = add_saturated(underflow_sum, weight);
         r.placement = PLACE_UNDERFLOW;
      end else if (value > edge_high) begin
         overflow_sum = add_saturated(overflow_sum, weight);
         r.placement = PLACE_OVERFLOW;
      end else begin
         if (log_binning)
            b = bin_from_offset(log2_fixed(value) - longint'(log_edge_low));
         else
            b = bin_from_offset(longint'(value) - longint'(edge_low));
         bin_weight[b] = add_saturated(bin_weight[b], weight);
         sq = {32'd0, err} * {32'd0, err};
         if (bin_error_sq[b] > 64'hFFFF_FFFF_FFFF_FFFF - sq)
            bin_error_sq[b] = 64'hFFFF_FFFF_FFFF_FFFF;
         else
            bin_error_sq[b] += sq;
         r.placement = PLACE_IN_RANGE;
         r.bin_index = b[9:0];
         r.bin_total = bin_weight[b][47:0];
         r.bin_error = root_floor(bin_error_sq[b]);
      end
      r.weight_total = weight_sum[47:0];
      r.underflow_total = underflow_sum[47:0];
      r.overflow_total = overflow_sum[47:0];
      return r;
   endfunction

   task automatic compare_field(string field, logic [63:0] expected, logic [63:0] actual);
      if (expected !== actual) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, field, expected, actual);
         error_count++;
      end
   endtask

   // Every accepted result is checked against the oldest outstanding fill.
   always @(posedge clock) begin
      fill_result_type want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = fill_result_type'(rsp_tdata[235:0]);
         if (pending_fills.size() == 0) begin
            $display("%0t: unexpected result item, actual %h", $time, rsp_tdata);
            error_count++;
         end else begin
            want = pending_fills.pop_front();
            got.placement = rsp_tdata[1:0];
            got.bin_index = rsp_tdata[11:2];
            got.bin_total = rsp_tdata[59:12];
            got.bin_error = rsp_tdata[91:60];
            got.weight_total = rsp_tdata[139:92];
            got.underflow_total = rsp_tdata[187:140];
            got.overflow_total = rsp_tdata[235:188];
            compare_field("placement", want.placement, got.placement);
            compare_field("bin_index", want.bin_index, got.bin_index);
            compare_field("bin_total", want.bin_total, got.bin_total);
            compare_field("bin_error", want.bin_error, got.bin_error);
            compare_field("weight_total", want.weight_total, got.weight_total);
            compare_field("underflow_total", want.underflow_total, got.underflow_total);
            compare_field("overflow_total", want.overflow_total, got.overflow_total);
         end
      end
   end

   // The watchdog ends a hung run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // The result side stalls in random bursts until the final quiet stretch.
   initial begin
      int n;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (!no_idling && $urandom_range(0, 5) == 0) begin
            rsp_tready = 1'b0;
            n = $urandom_range(1, 5);
            repeat (n - 1) @(negedge clock);
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   // Sends one sample item, optionally after an idle burst, and records the
   // expected result once the block has accepted it.
   task automatic send_sample(int value, int weight, bit [31:0] err);
      @(negedge clock);
      if (!no_idling && $urandom_range(0, 5) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = {err, weight, value};
      do @(posedge clock); while (!req_tready);
      pending_fills.push_back(fill_sample(value, weight, err));
   endtask

   // Waits until every outstanding result has arrived and the block is idle.
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_fills.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_INDEX_W-1:0] idx, bit [31:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_RANGE_LOW:     edge_low = value;
         CSR_RANGE_HIGH:    edge_high = value;
         CSR_BIN_FACTOR:    bins_per_unit = value;
         CSR_LOG_SCALE:     log_binning = value[0];
         CSR_LOG_RANGE_LOW: log_edge_low = value;
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic configure(int low, int high, bit [31:0] factor, bit use_log, int log_low);
      wait_idle();
      write_register(CSR_RANGE_LOW, low);
      write_register(CSR_RANGE_HIGH, high);
      write_register(CSR_BIN_FACTOR, factor);
      write_register(CSR_LOG_SCALE, {31'd0, use_log});
      write_register(CSR_LOG_RANGE_LOW, log_low);
   endtask

   // Random values mostly fall inside the current edges, with some on the
   // edges themselves and some anywhere in the field's range.
   function automatic int random_value();
      longint span;
      bit [63:0] r;
      int pick;
      span = longint'(edge_high) - longint'(edge_low);
      pick = $urandom_range(0, 9);
      r = {$urandom, $urandom};
      if (span >= 0 && pick < 7) return int'(longint'(edge_low) + longint'(r % (span + 1)));
      if (pick == 7) return edge_low;
      if (pick == 8) return edge_high;
      return $urandom;
   endfunction

   function automatic int random_weight();
      case ($urandom_range(0, 9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return $urandom >> $urandom_range(8, 31);
         default: return $urandom;
      endcase
   endfunction

   task automatic send_random(int count);
      repeat (count)
         send_sample(random_value(), random_weight(), $urandom >> $urandom_range(0, 31));
   endtask

   // Reset values: unit bins from zero, so the integer part picks the bin and
   // large values saturate to the last bin. Extremes of all three fields.
   task automatic test_reset_defaults();
      send_sample(0, 32'h0001_0000, 32'h0001_0000);
      send_sample(32'h0003_8000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_sample(32'h0003_0000, 32'h8000_0000, 32'hFFFF_FFFF);
      send_sample(32'h0003_0000, 32'h0, 32'hFFFF_FFFF);
      send_sample(32'h7FFF_FFFF, 32'h1234_5678, 32'h0);
      send_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001);
      send_sample(-1, 32'hFFFF_FFFF, 32'h8000_0000);
   endtask

   // Linear edges at -8.0 and +8.0 with 64 bins per unit: exactly 1024 bins,
   // so the upper edge lands on the last bin.
   task automatic test_linear_edges();
      configure(32'hFFF8_0000, 32'h0008_0000, 32'h0040_0000, 1'b0, 0);
      send_sample(32'hFFF8_0000, 32'h0002_0000, 32'h0000_8000);
      send_sample(32'hFFF7_FFFF, 32'h0002_0000, 32'h0000_8000);
      send_sample(32'h0008_0000, 32'h0003_0000, 32'h0001_0000);
      send_sample(32'h0008_0001, 32'hFFFF_0000, 32'h0001_0000);
      send_sample(32'h0000_0000, 32'h0000_0001, 32'h0000_0003);
      send_sample(32'h0000_0000, 32'h0000_0001, 32'h0000_0004);
   endtask

   // Lower edge above the upper edge: nothing can land in a bin.
   task automatic test_inverted_edges();
      configure(32'h0010_0000, 32'hFFF0_0000, 32'hFFFF_FFFF, 1'b0, 0);
      send_sample(32'h0000_0000, 32'h0001_0000, 32'h0001_0000);
      send_sample(32'h0010_0000, 32'h0001_0000, 32'h0001_0000);
      send_sample(32'hFFF0_0000, 32'h0001_0000, 32'h0001_0000);
   endtask

   // Log binning from a negative lower edge, so zero and negative values
   // must count as underflow; values below log_range_low clamp to bin 0.
   task automatic test_log_binning();
      configure(32'h8000_0000, 32'h7FFF_FFFF, 32'h0010_0000, 1'b1, 32'hFFFC_0000);
      send_sample(32'h0000_0000, 32'h0001_0000, 32'h0001_0000);
      send_sample(32'hFFFF_0000, 32'h0001_0000, 32'h0001_0000);
      send_sample(32'h0000_0001, 32'h0001_0000, 32'h0001_0000);
      send_sample(32'h0000_1000, 32'h0001_0000, 32'h0002_0000);
      send_sample(32'h0001_8000, 32'h0001_0000, 32'h0003_0000);
      send_sample(32'h7FFF_FFFF, 32'h0001_0000, 32'h0001_0000);
      send_sample(32'h0005_5555, 32'h0001_0000, 32'h0001_0000);
   endtask

   // Several random linear and log settings, including zero and full-scale
   // bin factors and small spans that make bins fill up repeatedly.
   task automatic test_random_settings();
      int low;
      for (int k = 0; k < 8; k++) begin
         case (k % 4)
            0: configure($urandom, $urandom, $urandom, 1'b0, $urandom);
            1: begin
               low = $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
               configure(low, low + $urandom_range(1, 32'h0004_0000),
                         (k == 5) ? 32'hFFFF_FFFF : $urandom_range(32'h0001_0000, 32'h0400_0000),
                         1'b0, $urandom);
            end
            2: configure($urandom_range(0, 32'h0001_0000), $urandom_range(32'h0010_0000,
                         32'h7FFF_FFFF), $urandom_range(32'h0001_0000, 32'h0040_0000), 1'b1,
                         int'($urandom_range(0, 32)) * 65536 - 32'h0010_0000);
            default: configure(32'h8000_0000, 32'h7FFF_FFFF, (k == 3) ? 32'd0 : $urandom,
                               1'b1, $urandom);
         endcase
         send_random(80);
      end
   endtask

   task automatic test_final_stream();
      configure(32'hFFF0_0000, 32'h0010_0000, 32'h0020_0000, 1'b0, 0);
      no_idling = 1'b1;
      send_random(100);
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_valid = 1'b0;
      csr_index = CSR_RANGE_LOW;
      csr_data = '0;
      no_idling = 1'b0;
      error_count = 0;
      cycle_count = 0;
      edge_low = 0;
      edge_high = 32'h7FFF_FFFF;
      bins_per_unit = 32'h0001_0000;
      log_binning = 1'b0;
      log_edge_low = 0;
      weight_sum = 0;
      underflow_sum = 0;
      overflow_sum = 0;
      for (int i = 0; i < BIN_COUNT_DEF; i++) begin
         bin_weight[i] = 0;
         bin_error_sq[i] = 0;
      end
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_linear_edges();
      test_inverted_edges();
      test_log_binning();
      test_random_settings();
      test_final_stream();
      wait_idle();

      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
